@@ sv/qcgm_pkg.sv @@
// Shared constants and the arctangent table for the quad corner geometry block.
// No dependencies; every other file but qcgm_delay refers to it by scoped names.
package qcgm_pkg;

    localparam int DW         = 64;      // CORDIC and square-root datapath width
    localparam int ZW         = 20;      // angle accumulator, Q16 radians, signed
    localparam int TAB_LEN    = 24;
    localparam int NORM_EXP   = 40;      // vectors are doubled up to 2^40
    localparam int NORM_STEPS = 6;       // shift steps of 32, 16, 8, 4, 2, 1
    localparam int CORDIC_FIX = 1 + NORM_STEPS;
    localparam int SQ_STAGES  = 32;      // one root bit per stage
    localparam int LEN_W      = 35;
    localparam int LSUM_W     = 37;
    localparam int MEAN_W     = 19;
    localparam int OUT_W      = 16;
    localparam int DEV_W      = ZW - 1;
    localparam int NUM_W      = DEV_W + 17;
    localparam int DIV_SHIFT  = 40;
    localparam int RECIP_W    = 23;

    localparam int unsigned PI_Q16      = 205887;
    localparam int unsigned HALF_PI_RND = 102943;
    localparam int unsigned HEAD_MAX    = 25736;
    localparam int unsigned SQ_ONE      = 32768;
    localparam longint unsigned DIV_RECIP = (64'd1 << DIV_SHIFT) / 64'd205887;

    function automatic logic [16:0] atan_q16(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/qcgm_delay.sv @@
// Fixed-length delay line used to line up results of lanes of unequal latency.
// Depends on nothing.
module qcgm_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    generate
        if (DEPTH == 0) begin : g_none
            assign o_q = i_d;
        end else begin : g_line
            logic [WIDTH-1:0] r_tap [0:DEPTH-1];
            always_ff @(posedge i_clk) begin
                r_tap[0] <= i_d;
                for (int i = 1; i < DEPTH; i++) begin
                    r_tap[i] <= r_tap[i-1];
                end
            end
            assign o_q = r_tap[DEPTH-1];
        end
    endgenerate

endmodule

@@ sv/qcgm_cordic.sv @@
// Pipelined vectoring CORDIC lane: atan2(y, x) in Q16 radians, zero for a zero vector.
// Depends on qcgm_pkg. Registered: the fold, each normalisation step, each rotation stage.
module qcgm_cordic #(
    parameter int STAGES = 16
) (
    input  logic                            i_clk,
    input  logic signed [qcgm_pkg::DW-1:0]  i_x,
    input  logic signed [qcgm_pkg::DW-1:0]  i_y,
    output logic signed [qcgm_pkg::ZW-1:0]  o_angle
);

    localparam int DW = qcgm_pkg::DW;
    localparam int ZW = qcgm_pkg::ZW;
    localparam int NS = qcgm_pkg::NORM_STEPS;
    localparam logic [DW-1:0] NORM_LIM = DW'(64'd1 << qcgm_pkg::NORM_EXP);
    localparam logic signed [ZW-1:0] PI_Z = ZW'(qcgm_pkg::PI_Q16);

    logic signed [DW-1:0] r_x [0:NS];
    logic signed [DW-1:0] r_y [0:NS];
    logic        [DW-1:0] r_m [0:NS];
    logic signed [ZW-1:0] r_z [0:NS];
    logic                 r_zero [0:NS];

    logic signed [DW-1:0] r_cx [1:STAGES];
    logic signed [DW-1:0] r_cy [1:STAGES];
    logic signed [ZW-1:0] r_cz [1:STAGES];
    logic                 r_czero [1:STAGES];

    // Fold the left half-plane onto the right one and note the larger magnitude.
    logic signed [DW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic        [DW-1:0] n_ay, n_m;
    always_comb begin
        if (i_x < 0) begin
            n_x = -i_x;
            n_y = -i_y;
            n_z = (n_y <= 0) ? PI_Z : -PI_Z;
        end else begin
            n_x = i_x;
            n_y = i_y;
            n_z = '0;
        end
        n_ay = (n_y < 0) ? DW'(-n_y) : DW'(n_y);
        n_m  = (DW'(n_x) > n_ay) ? DW'(n_x) : n_ay;
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x;
        r_y[0]    <= n_y;
        r_m[0]    <= n_m;
        r_z[0]    <= n_z;
        r_zero[0] <= (i_x == 0) && (i_y == 0);
    end

    // Normalise by binary steps; the last step adds the final doubling.
    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_norm
            localparam int K = 32 >> j;
            localparam logic [DW-1:0] LIM_K = DW'(64'd1 << (qcgm_pkg::NORM_EXP - K));
            logic signed [DW-1:0] n_sx, n_sy;
            logic        [DW-1:0] n_sm;
            always_comb begin
                if (r_m[j] < LIM_K) begin
                    n_sx = r_x[j] <<< K;
                    n_sy = r_y[j] <<< K;
                    n_sm = r_m[j] << K;
                end else begin
                    n_sx = r_x[j];
                    n_sy = r_y[j];
                    n_sm = r_m[j];
                end
                if ((j == NS - 1) && (n_sm < NORM_LIM)) begin
                    n_sx = n_sx <<< 1;
                    n_sy = n_sy <<< 1;
                    n_sm = n_sm << 1;
                end
            end
            always_ff @(posedge i_clk) begin
                r_x[j+1]    <= n_sx;
                r_y[j+1]    <= n_sy;
                r_m[j+1]    <= n_sm;
                r_z[j+1]    <= r_z[j];
                r_zero[j+1] <= r_zero[j];
            end
        end
    endgenerate

    genvar i;
    generate
        for (i = 0; i < STAGES; i++) begin : g_rot
            localparam logic signed [ZW-1:0] ATAN = ZW'(qcgm_pkg::atan_q16(5'(i)));
            logic signed [DW-1:0] x_in, y_in, n_rx, n_ry;
            logic signed [ZW-1:0] z_in, n_rz;
            logic                 zero_in;
            if (i == 0) begin : g_first
                assign x_in    = r_x[NS];
                assign y_in    = r_y[NS];
                assign z_in    = r_z[NS];
                assign zero_in = r_zero[NS];
            end else begin : g_next
                assign x_in    = r_cx[i];
                assign y_in    = r_cy[i];
                assign z_in    = r_cz[i];
                assign zero_in = r_czero[i];
            end
            always_comb begin
                if (y_in > 0) begin
                    n_rx = x_in + (y_in >>> i);
                    n_ry = y_in - (x_in >>> i);
                    n_rz = z_in + ATAN;
                end else if (y_in < 0) begin
                    n_rx = x_in - (y_in >>> i);
                    n_ry = y_in + (x_in >>> i);
                    n_rz = z_in - ATAN;
                end else begin
                    n_rx = x_in;
                    n_ry = y_in;
                    n_rz = z_in;
                end
            end
            always_ff @(posedge i_clk) begin
                r_cx[i+1]    <= n_rx;
                r_cy[i+1]    <= n_ry;
                r_cz[i+1]    <= n_rz;
                r_czero[i+1] <= zero_in;
            end
        end
    endgenerate

    assign o_angle = r_czero[STAGES] ? '0 : r_cz[STAGES];

endmodule

@@ sv/qcgm_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on qcgm_pkg.
module qcgm_isqrt (
    input  logic                     i_clk,
    input  logic [qcgm_pkg::DW-1:0]  i_n,
    output logic [31:0]              o_root
);

    localparam int DW = qcgm_pkg::DW;
    localparam int NS = qcgm_pkg::SQ_STAGES;

    logic [DW-1:0] r_n [1:NS];
    logic [DW-1:0] r_r [1:NS];

    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_bit
            localparam logic [DW-1:0] BIT = DW'(64'd1 << (62 - 2 * s));
            logic [DW-1:0] n_in, r_in, trial, n_nx, r_nx;
            if (s == 0) begin : g_first
                assign n_in = i_n;
                assign r_in = '0;
            end else begin : g_next
                assign n_in = r_n[s];
                assign r_in = r_r[s];
            end
            always_comb begin
                trial = r_in + BIT;
                if (n_in >= trial) begin
                    n_nx = n_in - trial;
                    r_nx = (r_in >> 1) + BIT;
                end else begin
                    n_nx = n_in;
                    r_nx = r_in >> 1;
                end
            end
            always_ff @(posedge i_clk) begin
                r_n[s+1] <= n_nx;
                r_r[s+1] <= r_nx;
            end
        end
    endgenerate

    assign o_root = r_r[NS][31:0];

endmodule

@@ sv/qcgm_merge.sv @@
// Merging stage: largest corner deviation to squareness, edge lengths to their mean.
// Depends on qcgm_pkg. Registers maximum and length sum, then the product, then the outputs.
module qcgm_merge (
    input  logic                                   i_clk,
    input  logic signed [qcgm_pkg::ZW-1:0]         i_dev [4],
    input  logic        [qcgm_pkg::LEN_W-1:0]      i_len [4],
    input  logic                                   i_degen,
    output logic        [qcgm_pkg::MEAN_W-1:0]     o_mean,
    output logic        [qcgm_pkg::OUT_W-1:0]      o_squareness,
    output logic                                   o_degenerate
);

    localparam int DEV_W  = qcgm_pkg::DEV_W;
    localparam int NUM_W  = qcgm_pkg::NUM_W;
    localparam int PROD_W = NUM_W + qcgm_pkg::RECIP_W;
    localparam int Q_W    = PROD_W - qcgm_pkg::DIV_SHIFT;
    localparam int LSUM_W = qcgm_pkg::LSUM_W;
    localparam logic [qcgm_pkg::RECIP_W-1:0] RECIP = qcgm_pkg::RECIP_W'(qcgm_pkg::DIV_RECIP);
    localparam logic [NUM_W-1:0] DIVISOR = NUM_W'(qcgm_pkg::PI_Q16);
    localparam logic [Q_W-1:0]   SQ_ONE  = Q_W'(qcgm_pkg::SQ_ONE);

    logic [DEV_W-1:0]  r_maxdev;
    logic [LSUM_W-1:0] r_lsum;
    logic              r_degen1, r_degen2;
    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  r_numer;
    logic [qcgm_pkg::MEAN_W-1:0] r_mean;

    logic [DEV_W-1:0]  n_maxdev;
    logic [LSUM_W-1:0] n_lsum;
    logic [NUM_W-1:0]  n_numer;
    logic [Q_W-1:0]    q0, q;
    logic [NUM_W-1:0]  rem;
    logic [LSUM_W-1:0] lsum_rnd;

    // A negative deviation never wins: the maximum starts at zero.
    always_comb begin
        n_maxdev = '0;
        n_lsum   = '0;
        for (int k = 0; k < 4; k++) begin
            if (i_dev[k] > signed'({1'b0, n_maxdev})) begin
                n_maxdev = i_dev[k][DEV_W-1:0];
            end
            n_lsum = n_lsum + LSUM_W'(i_len[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_maxdev <= n_maxdev;
        r_lsum   <= n_lsum;
        r_degen1 <= i_degen;
    end

    // Divide by pi in Q16 as a reciprocal product; one correction step follows.
    assign n_numer  = {r_maxdev, 16'd0} + NUM_W'(qcgm_pkg::HALF_PI_RND);
    assign lsum_rnd = r_lsum + LSUM_W'(8);

    always_ff @(posedge i_clk) begin
        r_prod   <= PROD_W'(n_numer) * PROD_W'(RECIP);
        r_numer  <= n_numer;
        r_mean   <= lsum_rnd[qcgm_pkg::MEAN_W+3:4];
        r_degen2 <= r_degen1;
    end

    always_comb begin
        q0  = r_prod[PROD_W-1:qcgm_pkg::DIV_SHIFT];
        rem = r_numer - NUM_W'(NUM_W'(q0) * DIVISOR);
        q   = (rem >= DIVISOR) ? q0 + Q_W'(1) : q0;
    end

    always_ff @(posedge i_clk) begin
        o_mean       <= r_mean;
        o_degenerate <= r_degen2;
        if (r_degen2 || (q > SQ_ONE)) begin
            o_squareness <= '0;
        end else begin
            o_squareness <= qcgm_pkg::OUT_W'(SQ_ONE - q);
        end
    end

endmodule

@@ sv/quad_corner_geometry_metrics.sv @@
// Top level of the quad corner geometry block: edge and corner lanes plus merge.
// Depends on qcgm_pkg, qcgm_delay, qcgm_cordic, qcgm_isqrt and qcgm_merge.

// A new quad may be started on every clock cycle; busy never rises. Each beat gives
// one result, marked by o_done for a single cycle. The 32-stage square-root lanes of
// the edge lengths, or the CORDIC lanes of the corner angles when they are longer,
// set when the result appears. The receiver must take each result in the cycle it
// appears, as results are not held.
module quad_corner_geometry_metrics #(
    parameter int COORD_WIDTH   = 18,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_corner0_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner0_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner1_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner1_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner2_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner2_y,
    input  logic signed [COORD_WIDTH-1:0] i_corner3_x,
    input  logic signed [COORD_WIDTH-1:0] i_corner3_y,
    output logic                          o_done,
    output logic signed [15:0]            o_heading_angle,
    output logic        [18:0]            o_mean_edge_length,
    output logic        [15:0]            o_squareness,
    output logic                          o_degenerate
);

    localparam int DW     = qcgm_pkg::DW;
    localparam int ZW     = qcgm_pkg::ZW;
    localparam int LEN_W  = qcgm_pkg::LEN_W;
    localparam int DXW    = COORD_WIDTH + 2;
    localparam int EXW    = COORD_WIDTH + 1;
    localparam int PRE    = (COORD_WIDTH > 29) ? COORD_WIDTH - 29 : 0;
    localparam int EW     = EXW - PRE;
    localparam int PW     = 2 * EW;
    localparam int LC     = qcgm_pkg::CORDIC_FIX + CORDIC_STAGES;
    localparam int T_DEV  = 3 + LC;
    localparam int T_LEN  = 3 + qcgm_pkg::SQ_STAGES;
    localparam int TA     = (T_DEV > T_LEN) ? T_DEV : T_LEN;
    localparam int LAT    = TA + 3;
    localparam logic signed [ZW-1:0] HMAX = ZW'(qcgm_pkg::HEAD_MAX);
    localparam logic signed [15:0]   HMAX_OUT = 16'(qcgm_pkg::HEAD_MAX);

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Result strobe follows the accepted beat through the whole pipeline.
    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end
    assign o_done = r_vld[LAT-1];

    logic signed [COORD_WIDTH-1:0] cx [4];
    logic signed [COORD_WIDTH-1:0] cy [4];
    assign cx[0] = i_corner0_x;  assign cy[0] = i_corner0_y;
    assign cx[1] = i_corner1_x;  assign cy[1] = i_corner1_y;
    assign cx[2] = i_corner2_x;  assign cy[2] = i_corner2_y;
    assign cx[3] = i_corner3_x;  assign cy[3] = i_corner3_y;

    // First stage: midpoint difference, closed-loop edge vectors, zero-edge check.
    logic signed [DXW-1:0] r_dx, r_dy;
    logic signed [EW-1:0]  r_ex [4];
    logic signed [EW-1:0]  r_ey [4];
    logic                  r_degen;
    logic signed [EXW-1:0] n_rx [4];
    logic signed [EXW-1:0] n_ry [4];
    logic                  n_degen;

    always_comb begin
        n_degen = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n_rx[k] = EXW'(cx[(k + 1) % 4]) - EXW'(cx[k]);
            n_ry[k] = EXW'(cy[(k + 1) % 4]) - EXW'(cy[k]);
            if ((n_rx[k] == 0) && (n_ry[k] == 0)) begin
                n_degen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx    <= (DXW'(cx[1]) + DXW'(cx[2])) - (DXW'(cx[0]) + DXW'(cx[3]));
        r_dy    <= (DXW'(cy[1]) + DXW'(cy[2])) - (DXW'(cy[0]) + DXW'(cy[3]));
        r_degen <= n_degen;
        for (int k = 0; k < 4; k++) begin
            r_ex[k] <= EW'(n_rx[k] >>> PRE);
            r_ey[k] <= EW'(n_ry[k] >>> PRE);
        end
    end

    // Heading lane.
    logic signed [ZW-1:0] head_z, head_full;
    logic signed [15:0]   r_head;
    qcgm_cordic #(.STAGES(CORDIC_STAGES)) u_head (
        .i_clk   (i_clk),
        .i_x     (DW'(r_dx)),
        .i_y     (DW'(r_dy)),
        .o_angle (head_z)
    );

    assign head_full = (head_z + ZW'(4)) >>> 3;
    always_ff @(posedge i_clk) begin
        if (head_full > HMAX) begin
            r_head <= HMAX_OUT;
        end else if (head_full < -HMAX) begin
            r_head <= -HMAX_OUT;
        end else begin
            r_head <= 16'(head_full);
        end
    end

    qcgm_delay #(.WIDTH(16), .DEPTH(LAT - (2 + LC))) u_head_dly (
        .i_clk (i_clk),
        .i_d   (r_head),
        .o_q   (o_heading_angle)
    );

    // Second stage: squares for the edge lanes, products for the corner lanes.
    // Corner k sits between edge k-1 (reversed) and edge k.
    logic signed [PW-1:0] r_sqx [4];
    logic signed [PW-1:0] r_sqy [4];
    logic signed [PW-1:0] r_pxx [4];
    logic signed [PW-1:0] r_pyy [4];
    logic signed [PW-1:0] r_pxy [4];
    logic signed [PW-1:0] r_pyx [4];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_sqx[k] <= PW'(r_ex[k]) * PW'(r_ex[k]);
            r_sqy[k] <= PW'(r_ey[k]) * PW'(r_ey[k]);
            r_pxx[k] <= PW'(r_ex[(k + 3) % 4]) * PW'(r_ex[k]);
            r_pyy[k] <= PW'(r_ey[(k + 3) % 4]) * PW'(r_ey[k]);
            r_pxy[k] <= PW'(r_ex[(k + 3) % 4]) * PW'(r_ey[k]);
            r_pyx[k] <= PW'(r_ey[(k + 3) % 4]) * PW'(r_ex[k]);
        end
    end

    // Third stage: scaled squared length, and magnitudes of dot and cross.
    logic        [DW-1:0] r_sum [4];
    logic signed [DW-1:0] r_dot [4];
    logic signed [DW-1:0] r_crs [4];
    logic signed [PW:0]   n_dot [4];
    logic signed [PW:0]   n_crs [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_dot[k] = (PW+1)'(r_pxx[k]) + (PW+1)'(r_pyy[k]);
            n_crs[k] = (PW+1)'(r_pxy[k]) - (PW+1)'(r_pyx[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_sum[k] <= (DW'(r_sqx[k]) + DW'(r_sqy[k])) << 4;
            r_dot[k] <= (n_dot[k] < 0) ? DW'(-n_dot[k]) : DW'(n_dot[k]);
            r_crs[k] <= (n_crs[k] < 0) ? DW'(-n_crs[k]) : DW'(n_crs[k]);
        end
    end

    // Lanes: one square root per edge and one CORDIC per corner.
    logic signed [ZW-1:0]    dev [4];
    logic        [31:0]      root [4];
    logic [4*ZW-1:0]         dev_pk, dev_al_pk;
    logic [4*LEN_W-1:0]      len_pk, len_al_pk;
    logic signed [ZW-1:0]    dev_al [4];
    logic        [LEN_W-1:0] len_al [4];
    logic                    degen_al;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            qcgm_isqrt u_sqrt (
                .i_clk  (i_clk),
                .i_n    (r_sum[g]),
                .o_root (root[g])
            );
            qcgm_cordic #(.STAGES(CORDIC_STAGES)) u_corner (
                .i_clk   (i_clk),
                .i_x     (r_crs[g]),
                .i_y     (r_dot[g]),
                .o_angle (dev[g])
            );
            assign dev_pk[g*ZW +: ZW]       = dev[g];
            assign len_pk[g*LEN_W +: LEN_W] = LEN_W'(root[g]) << PRE;
            assign dev_al[g]                = dev_al_pk[g*ZW +: ZW];
            assign len_al[g]                = len_al_pk[g*LEN_W +: LEN_W];
        end
    endgenerate

    qcgm_delay #(.WIDTH(4 * ZW), .DEPTH(TA - T_DEV)) u_dev_dly (
        .i_clk (i_clk),
        .i_d   (dev_pk),
        .o_q   (dev_al_pk)
    );

    qcgm_delay #(.WIDTH(4 * LEN_W), .DEPTH(TA - T_LEN)) u_len_dly (
        .i_clk (i_clk),
        .i_d   (len_pk),
        .o_q   (len_al_pk)
    );

    qcgm_delay #(.WIDTH(1), .DEPTH(TA - 1)) u_degen_dly (
        .i_clk (i_clk),
        .i_d   (r_degen),
        .o_q   (degen_al)
    );

    qcgm_merge u_merge (
        .i_clk        (i_clk),
        .i_dev        (dev_al),
        .i_len        (len_al),
        .i_degen      (degen_al),
        .o_mean       (o_mean_edge_length),
        .o_squareness (o_squareness),
        .o_degenerate (o_degenerate)
    );

    // A quad with a zero-length edge scores nothing.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |-> (o_squareness == '0))
        else $error("degenerate quad with nonzero squareness");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_heading_angle <= HMAX_OUT) && (o_heading_angle >= -HMAX_OUT)))
        else $error("heading outside clamp range");

    a_sq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_squareness <= 16'(qcgm_pkg::SQ_ONE)))
        else $error("squareness above one");

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_vld[LAT-2]) |-> $past(r_vld[LAT-3]))
        else $error("result strobe lost its beat");

endmodule

@@ sim/tb_quad_corner_geometry_metrics.sv @@
// Self-checking testbench for quad_corner_geometry_metrics: directed and random quads.
// A scoreboard class predicts heading, mean edge length, squareness and the degenerate flag for every beat.
// Depends on qcgm_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_quad_corner_geometry_metrics;

    localparam int CW       = 18;
    localparam int STAGES   = 16;
    localparam int N_RANDOM = 1525;
    localparam int IDLE_MAX = 3000;
    localparam int TAIL     = 60;

    typedef logic signed [CW-1:0] quad_t [8];

    typedef struct {
        logic signed [15:0] heading;
        logic [18:0]        mean_len;
        logic [15:0]        square;
        logic               degen;
    } metrics_t;

    class metrics_scoreboard;
        metrics_t pending[$];
        int       n_errors;
        int       n_checked;
        int       n_degen;

        function automatic longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned bitv;
            r = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= r + bitv) begin
                    n = n - (r + bitv);
                    r = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
            return r;
        endfunction

        // Vectoring rotation, angle in Q16 radians; the zero vector gives 0.
        function automatic longint vector_angle(longint x, longint y);
            longint z;
            longint m;
            longint xs;
            longint ys;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = (y <= 0) ? longint'(qcgm_pkg::PI_Q16) : -longint'(qcgm_pkg::PI_Q16);
            end
            m = ((x < 0 ? -x : x) > (y < 0 ? -y : y)) ? (x < 0 ? -x : x) : (y < 0 ? -y : y);
            while (m < (64'sd1 <<< 40)) begin
                x = x * 2;
                y = y * 2;
                m = m * 2;
            end
            for (int i = 0; i < STAGES && i < qcgm_pkg::TAB_LEN; i++) begin
                xs = floor_shr(x, i);
                ys = floor_shr(y, i);
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(qcgm_pkg::atan_q16(5'(i)));
                end else if (y < 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(qcgm_pkg::atan_q16(5'(i)));
                end
            end
            return z;
        endfunction

        function automatic metrics_t predict(quad_t q);
            metrics_t r;
            longint cx[4];
            longint cy[4];
            longint ex[4];
            longint ey[4];
            longint dx;
            longint dy;
            longint h;
            longint maxdev;
            longint sq;
            longint dot;
            longint crs;
            longint dev;
            longint unsigned lsum;
            logic degen;
            int p;
            for (int k = 0; k < 4; k++) begin
                cx[k] = longint'(q[2*k]);
                cy[k] = longint'(q[2*k+1]);
            end
            dx = (cx[1] + cx[2]) - (cx[0] + cx[3]);
            dy = (cy[1] + cy[2]) - (cy[0] + cy[3]);
            h = floor_shr(vector_angle(dx, dy) + 4, 3);
            if (h > longint'(qcgm_pkg::HEAD_MAX)) h = longint'(qcgm_pkg::HEAD_MAX);
            if (h < -longint'(qcgm_pkg::HEAD_MAX)) h = -longint'(qcgm_pkg::HEAD_MAX);
            lsum = 0;
            degen = 1'b0;
            for (int k = 0; k < 4; k++) begin
                ex[k] = cx[(k+1)%4] - cx[k];
                ey[k] = cy[(k+1)%4] - cy[k];
                if (ex[k] == 0 && ey[k] == 0) degen = 1'b1;
                lsum = lsum + int_sqrt(longint'(ex[k]*ex[k] + ey[k]*ey[k]) << 4);
            end
            maxdev = 0;
            for (int k = 0; k < 4; k++) begin
                p = (k + 3) % 4;
                dot = -ex[p] * ex[k] - ey[p] * ey[k];
                crs = -ex[p] * ey[k] + ey[p] * ex[k];
                dev = vector_angle(crs < 0 ? -crs : crs, dot < 0 ? -dot : dot);
                if (dev > maxdev) maxdev = dev;
            end
            sq = 32768 - (maxdev * 65536 + qcgm_pkg::HALF_PI_RND) / qcgm_pkg::PI_Q16;
            if (sq < 0) sq = 0;
            if (sq > 32768) sq = 32768;
            if (degen) sq = 0;
            r.heading  = h[15:0];
            r.mean_len = 19'((lsum + 8) >> 4);
            r.square   = sq[15:0];
            r.degen    = degen;
            return r;
        endfunction

        function void note_quad(quad_t q);
            pending.push_back(predict(q));
        endfunction

        function void check_metrics(metrics_t got);
            metrics_t exp_m;
            if (pending.size() == 0) begin
                $error("result with no quad outstanding");
                n_errors++;
                return;
            end
            exp_m = pending.pop_front();
            n_checked++;
            if (got.degen) n_degen++;
            if (got.heading !== exp_m.heading) begin
                $error("heading_angle: expected %0d, actual %0d", exp_m.heading, got.heading);
                n_errors++;
            end
            if (got.mean_len !== exp_m.mean_len) begin
                $error("mean_edge_length: expected %0d, actual %0d",
                       exp_m.mean_len, got.mean_len);
                n_errors++;
            end
            if (got.square !== exp_m.square) begin
                $error("squareness: expected %0d, actual %0d", exp_m.square, got.square);
                n_errors++;
            end
            if (got.degen !== exp_m.degen) begin
                $error("degenerate: expected %0d, actual %0d", exp_m.degen, got.degen);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [CW-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
    logic o_done;
    logic signed [15:0] o_heading_angle;
    logic [18:0] o_mean_edge_length;
    logic [15:0] o_squareness;
    logic o_degenerate;

    metrics_scoreboard sb;
    int idle_cycles;
    int n_sent;

    quad_corner_geometry_metrics #(.COORD_WIDTH(CW), .CORDIC_STAGES(STAGES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_corner0_x(c0x), .i_corner0_y(c0y), .i_corner1_x(c1x), .i_corner1_y(c1y),
        .i_corner2_x(c2x), .i_corner2_y(c2y), .i_corner3_x(c3x), .i_corner3_y(c3y),
        .o_done(o_done), .o_heading_angle(o_heading_angle),
        .o_mean_edge_length(o_mean_edge_length), .o_squareness(o_squareness),
        .o_degenerate(o_degenerate)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Accepted beats in both directions are sampled here, once per rising edge.
    always @(posedge i_clk) begin
        quad_t q;
        metrics_t got;
        if (i_rst_n) begin
            idle_cycles = idle_cycles + 1;
            if (start && !busy) begin
                q = '{c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y};
                sb.note_quad(q);
                idle_cycles = 0;
            end
            if (o_done) begin
                got.heading  = o_heading_angle;
                got.mean_len = o_mean_edge_length;
                got.square   = o_squareness;
                got.degen    = o_degenerate;
                sb.check_metrics(got);
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_MAX) begin
                $display("Timeout: no beat accepted for %0d cycles", IDLE_MAX);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Drives one quad from this edge and returns at the edge that accepts it.
    task automatic drive_quad(quad_t q);
        start <= 1'b1;
        c0x <= q[0]; c0y <= q[1]; c1x <= q[2]; c1y <= q[3];
        c2x <= q[4]; c2y <= q[5]; c3x <= q[6]; c3y <= q[7];
        do @(posedge i_clk); while (busy);
        n_sent++;
    endtask

    task automatic idle_for(int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [CW-1:0] pick_edge_value();
        case ($urandom_range(0, 5))
            0: return CW'(-(1 <<< (CW-1)));
            1: return CW'((1 <<< (CW-1)) - 1);
            2: return CW'(0);
            3: return CW'(-1);
            4: return CW'(1);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic logic signed [CW-1:0] clip(longint v);
        if (v > (1 <<< (CW-1)) - 1) return CW'((1 <<< (CW-1)) - 1);
        if (v < -(1 <<< (CW-1))) return CW'(-(1 <<< (CW-1)));
        return CW'(v);
    endfunction

    function automatic quad_t random_quad();
        quad_t q;
        longint ox, oy, w, hgt, span;
        int dup;
        ox = longint'($signed(CW'($urandom)));
        oy = longint'($signed(CW'($urandom)));
        case ($urandom_range(0, 9))
            0, 1: begin
                for (int k = 0; k < 8; k++) q[k] = CW'($urandom);
            end
            2: begin
                for (int k = 0; k < 8; k++) q[k] = pick_edge_value();
            end
            3, 4: begin
                // Axis-aligned rectangle, possibly flattened to a line.
                w = longint'($urandom_range(0, 4000)) - 2000;
                hgt = longint'($urandom_range(0, 4000)) - 2000;
                q = '{clip(ox), clip(oy), clip(ox + w), clip(oy), clip(ox + w),
                      clip(oy + hgt), clip(ox), clip(oy + hgt)};
            end
            5: begin
                // Rectangle with a repeated corner.
                w = $urandom_range(1, 800);
                hgt = $urandom_range(1, 800);
                q = '{clip(ox), clip(oy), clip(ox + w), clip(oy), clip(ox + w),
                      clip(oy + hgt), clip(ox), clip(oy + hgt)};
                dup = $urandom_range(0, 3);
                q[2*((dup+1)%4)]   = q[2*dup];
                q[2*((dup+1)%4)+1] = q[2*dup+1];
            end
            default: begin
                // Perturbed quad around a random centre, mostly small sizes.
                span = ($urandom_range(0, 7) == 0) ? 60000 : $urandom_range(1, 600);
                for (int k = 0; k < 4; k++) begin
                    q[2*k]   = clip(ox + $signed($urandom_range(0, 2*span)) - span);
                    q[2*k+1] = clip(oy + $signed($urandom_range(0, 2*span)) - span);
                end
            end
        endcase
        return q;
    endfunction

    task automatic run_directed();
        quad_t d[$];
        logic signed [CW-1:0] mx, mn;
        mx = CW'((1 <<< (CW-1)) - 1);
        mn = CW'(-(1 <<< (CW-1)));
        d.push_back('{0, 0, 0, 0, 0, 0, 0, 0});
        d.push_back('{mx, mx, mx, mx, mx, mx, mx, mx});
        d.push_back('{mn, mn, mx, mn, mx, mx, mn, mx});
        d.push_back('{mx, mx, mn, mx, mn, mn, mx, mn});
        d.push_back('{mn, mx, mx, mn, mn, mx, mx, mn});
        d.push_back('{0, 0, 8, 0, 8, 8, 0, 8});
        d.push_back('{0, 0, 80, 0, 80, 24, 0, 24});
        d.push_back('{0, 0, 0, 8, -8, 8, -8, 0});
        d.push_back('{0, 0, 10, 0, 20, 0, 30, 0});
        d.push_back('{0, 0, -10, 0, -10, 5, 0, 5});
        d.push_back('{0, 0, -10, 0, -10, -5, 0, -5});
        d.push_back('{0, 0, 0, -10, 5, -10, 5, 0});
        d.push_back('{0, 0, 1, 0, 1, 1, 0, 1});
        d.push_back('{5, 5, 5, 5, 40, 40, 5, 40});
        d.push_back('{0, 0, 100, 3, 97, 103, -3, 100});
        d.push_back('{-1, -1, -1, -1, -1, -1, -1, -1});
        d.push_back('{0, 0, 100, 0, 150, 80, 50, 80});
        d.push_back('{0, 0, 16, 0, 0, 16, 16, 16});
        d.push_back('{mx, 0, 0, mx, mn, 0, 0, mn});
        d.push_back('{1, mn, mn, 1, mx, 1, 1, mx});
        foreach (d[i]) drive_quad(d[i]);
    endtask

    initial begin
        int burst;
        sb = new();
        idle_cycles = 0;
        n_sent = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        {c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y} = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        idle_for($urandom_range(0, 5));

        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) drive_quad(random_quad());
            if (n >= N_RANDOM / 2 && n - burst < N_RANDOM / 2) begin
                // Let the pipeline drain fully once mid-run.
                start <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                idle_for($urandom_range(1, 45));
            end
        end
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);

        $display("Sent %0d quads, checked %0d results, %0d of them degenerate.",
                 n_sent, sb.n_checked, sb.n_degen);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/qcgm_pkg.sv
sv/qcgm_delay.sv
sv/qcgm_cordic.sv
sv/qcgm_isqrt.sv
sv/qcgm_merge.sv
sv/quad_corner_geometry_metrics.sv
sim/tb_quad_corner_geometry_metrics.sv
